>>> rtl/pclm_pkg.sv
// Shared types, constants and the CRC-8 byte function for the packet CRC link monitor.
package pclm_pkg;

   // Configuration register indexes
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_SIGNAL_FLOOR = 1'd1;

   localparam logic [15:0] TimeoutReset = 16'd1000;
   localparam logic signed [8:0] FloorReset = -9'sd130;

   // CRC-8, reflected, polynomial 0x8C, initial value zero
   localparam logic [7:0] CrcPoly = 8'h8C;
   localparam logic [7:0] CrcInit = 8'h00;

   // Bar mapping thresholds in dBm
   localparam logic signed [8:0] RawOffset = 9'sd255;
   localparam logic signed [8:0] ClampDbm = -9'sd91;
   localparam logic signed [8:0] RedTopDbm = -9'sd62;
   localparam logic signed [8:0] YellowTopDbm = -9'sd32;
   localparam logic signed [8:0] RedBase = 9'sd91;
   localparam logic signed [8:0] YellowBase = 9'sd61;
   localparam logic signed [8:0] GreenBase = 9'sd31;

   // x*7/29 and x*7/31 for x up to 31 as x*M >> 13 (reciprocal of the divisor times seven)
   localparam logic [10:0] Div29Mul = 11'd1981;
   localparam logic [10:0] Div31Mul = 11'd1855;
   localparam int DivShift = 13;
   localparam logic [3:0] LevelFull = 4'd8;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      EV_PACKET = 1'b0,
      EV_SIGNAL_LOST = 1'b1
   } event_type;

   typedef enum logic [1:0] {
      COLOR_RED = 2'd0,
      COLOR_YELLOW = 2'd1,
      COLOR_GREEN = 2'd2
   } color_type;

   typedef struct packed {
      op_type operation;
      logic [7:0] byte_value;
      logic [7:0] rssi_raw;
   } item_type;

   typedef struct packed {
      logic [3:0] level;
      color_type color;
   } bar_type;

   typedef struct packed {
      event_type event_kind;
      logic crc_ok;
      logic [31:0] packet_total;
      logic [31:0] error_total;
      logic signed [8:0] signal_dbm;
      logic bar_update;
      logic [3:0] bar_level;
      color_type bar_color;
   } result_type;

   typedef struct packed {
      logic present;
      logic [3:0] shown_level;
      color_type shown_color;
   } status_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] crc;
      logic [7:0] b;
      logic mix;
      crc = crc_in;
      b = data;
      for (int i = 0; i < 8; i++) begin
         mix = crc[0] ^ b[0];
         crc = crc >> 1;
         if (mix) begin
            crc = crc ^ CrcPoly;
         end
         b = b >> 1;
      end
      return crc;
   endfunction

endpackage

>>> rtl/pclm_bar_map.sv
// Maps a signal strength in dBm to a bar level of 1 to 8 and a colour band.
module pclm_bar_map (
   input  logic signed [8:0] dbm,
   output pclm_pkg::bar_type bar
);
   import pclm_pkg::*;

   logic signed [8:0] clamped;
   logic signed [8:0] offset;
   logic [10:0] mul;
   logic [15:0] product;
   color_type color;

   always_comb begin
      clamped = (dbm < ClampDbm) ? ClampDbm : dbm;
      priority if (clamped <= RedTopDbm) begin
         color = COLOR_RED;
         offset = clamped + RedBase;
         mul = Div29Mul;
      end else if (clamped <= YellowTopDbm) begin
         color = COLOR_YELLOW;
         offset = clamped + YellowBase;
         mul = Div29Mul;
      end else begin
         color = COLOR_GREEN;
         offset = clamped + GreenBase;
         mul = Div31Mul;
      end
      // The offset lies in 0 to 31 inside each band.
      product = 16'(offset[4:0]) * 16'(mul);
      bar.level = {1'b0, product[DivShift +: 3]} + 4'd1;
      bar.color = color;
   end

endmodule

>>> rtl/pclm_tracker.sv
// Packet state, CRC check, counters, idle timer and bar display tracking.
module pclm_tracker #(
   parameter int PACKET_BYTES = 44
) (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  pclm_pkg::item_type item,
   input  logic [15:0] timeout_ticks,
   input  logic signed [8:0] signal_floor_dbm,
   output logic res_valid,
   output pclm_pkg::result_type result,
   output pclm_pkg::status_type status
);
   import pclm_pkg::*;

   localparam int PosW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam logic [PosW-1:0] LastPos = PosW'(PACKET_BYTES - 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [31:0] pkt_ff, pkt_in;
   logic [31:0] err_ff, err_in;
   logic [15:0] idle_ff, idle_in;
   status_type shown_ff, shown_in;

   logic [15:0] idle_sat;
   logic signed [8:0] dbm;
   logic crc_match;
   logic above_floor;
   logic changed;
   bar_type bar;

   pclm_bar_map u_bar_map (
      .dbm(dbm),
      .bar(bar)
   );

   always_comb begin
      idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      dbm = $signed({1'b0, item.rssi_raw}) - RawOffset;
      crc_match = (crc_ff == item.byte_value);
      above_floor = (dbm >= signal_floor_dbm);
      changed = (bar.level != shown_ff.shown_level) || (bar.color != shown_ff.shown_color)
                || !shown_ff.present;
   end

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      pkt_in = pkt_ff;
      err_in = err_ff;
      idle_in = idle_ff;
      shown_in = shown_ff;
      res_valid = 1'b0;
      result.event_kind = EV_PACKET;
      result.crc_ok = 1'b0;
      result.packet_total = pkt_ff;
      result.error_total = err_ff;
      result.signal_dbm = '0;
      result.bar_update = 1'b0;
      result.bar_level = '0;
      result.bar_color = COLOR_RED;
      unique case (item.operation)
         OP_TICK: begin
            idle_in = idle_sat;
            if (idle_sat >= timeout_ticks && shown_ff.present) begin
               res_valid = 1'b1;
               result.event_kind = EV_SIGNAL_LOST;
               result.bar_update = 1'b1;
               result.bar_level = LevelFull;
               shown_in.present = 1'b0;
               shown_in.shown_level = '0;
               shown_in.shown_color = COLOR_RED;
            end
         end
         OP_BYTE: begin
            if (pos_ff != LastPos) begin
               crc_in = crc8_byte(crc_ff, item.byte_value);
               pos_in = pos_ff + PosW'(1);
            end else begin
               res_valid = 1'b1;
               pos_in = '0;
               crc_in = CrcInit;
               idle_in = '0;
               pkt_in = pkt_ff + 32'd1;
               err_in = crc_match ? err_ff : err_ff + 32'd1;
               result.crc_ok = crc_match;
               result.packet_total = pkt_in;
               result.error_total = err_in;
               result.signal_dbm = dbm;
               // Below the floor the bar is left as it is and the fields read zero.
               if (above_floor) begin
                  result.bar_level = bar.level;
                  result.bar_color = bar.color;
                  result.bar_update = changed;
                  if (changed) begin
                     shown_in.present = 1'b1;
                     shown_in.shown_level = bar.level;
                     shown_in.shown_color = bar.color;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CrcInit;
         pkt_ff <= '0;
         err_ff <= '0;
         idle_ff <= '0;
         shown_ff <= '0;
      end else if (step_en) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         pkt_ff <= pkt_in;
         err_ff <= err_in;
         idle_ff <= idle_in;
         shown_ff <= shown_in;
      end
   end

   assign status = shown_ff;

endmodule

>>> rtl/packet_crc_link_monitor_core.sv
// Top level of the packet CRC link monitor: input register, tracker and result register.
//
// Input words on req_ carry either one packet byte (req_tuser low) or one millisecond
// tick (req_tuser high). Every PACKET_BYTES-th byte closes a packet: it is compared with
// the reflected CRC-8 of the bytes before it and, with the RSSI sent alongside, gives one
// result word on rsp_ with the packet and error totals, the level in dBm and the bar
// level and colour. A tick gives a signal-lost word once the idle time reaches
// timeout_ticks while a bar is shown. All other words give no result.
// A word is held in the input register and processed there, and its result lands in the
// result register, which drives rsp_tvalid.
// One word is taken every cycle as long as the result register is empty or being read.
// When rsp_tready stays low the full result register holds its word; words that give no
// result still pass, and req_tready drops only when a result is waiting behind it.
// The csr_ port writes timeout_ticks (index 0) and signal_floor_dbm (index 1); the user
// must make writes only while the block is idle, and the block itself does not enforce it.
// Synchronous reset clears the counters, the CRC, the byte position and the bar state,
// empties both registers and restores the registers to 1000 ticks and -130 dBm.
module packet_crc_link_monitor_core #(
   parameter int PACKET_BYTES = 44
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // byte_value[7:0], rssi_raw[15:8]
   input  logic req_tuser,          // operation
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [87:0] rsp_tdata,   // crc_ok, packet_total, error_total, signal_dbm,
                                    // bar_update, bar_level, bar_color, zero fill
   output logic rsp_tuser,          // event_kind
   input  logic csr_we,
   input  logic [pclm_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pclm_pkg::CsrDataW-1:0] csr_wdata
);
   import pclm_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic [15:0] timeout_ff;
   logic signed [8:0] floor_ff;

   logic res_valid;
   result_type result;
   status_type status;
   logic out_free;
   logic step;
   logic req_take;

   pclm_tracker #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_tracker (
      .clock(clock),
      .reset(reset),
      .step_en(step),
      .item(s1_item_ff),
      .timeout_ticks(timeout_ff),
      .signal_floor_dbm(floor_ff),
      .res_valid(res_valid),
      .result(result),
      .status(status)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      step = s1_valid_ff && (!res_valid || out_free);
      req_tready = !s1_valid_ff || step;
      req_take = req_tvalid && req_tready;
      s1_valid_in = req_take ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (step && res_valid) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff <= TimeoutReset;
         floor_ff <= FloorReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
               CSR_SIGNAL_FLOOR: floor_ff <= $signed(csr_wdata[8:0]);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.operation <= op_type'(req_tuser);
         s1_item_ff.byte_value <= req_tdata[7:0];
         s1_item_ff.rssi_raw <= req_tdata[15:8];
      end
      if (step && res_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.event_kind;
   assign rsp_tdata = {7'd0, rsp_ff.bar_color, rsp_ff.bar_level, rsp_ff.bar_update,
                       rsp_ff.signal_dbm, rsp_ff.error_total, rsp_ff.packet_total,
                       rsp_ff.crc_ok};

   // A shown bar always has a real level; with no signal nothing is shown.
   assert property (@(posedge clock) disable iff (reset)
      status.present |-> (status.shown_level >= 4'd1 && status.shown_level <= LevelFull))
      else $error("shown bar level out of range");

   assert property (@(posedge clock) disable iff (reset)
      !status.present |-> (status.shown_level == 4'd0 && status.shown_color == COLOR_RED))
      else $error("bar state not cleared without signal");

   // A waiting signal-lost word means the bar state has been dropped.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_kind == EV_SIGNAL_LOST) |-> !status.present)
      else $error("signal still present after loss report");

   // A waiting redraw request matches what the tracker now shows.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_kind == EV_PACKET && rsp_ff.bar_update)
      |-> (status.present && status.shown_level == rsp_ff.bar_level
           && status.shown_color == rsp_ff.bar_color))
      else $error("redraw word disagrees with shown bar");

endmodule
